@@ rtl/sstc_pkg.sv @@
// ---------------------------------------------------------------------------
// Sensor slot table classifier package
// Shared types, register indexes, reset values and icon functions.
// ---------------------------------------------------------------------------
package sstc_pkg;

   localparam int MAC_W   = 48;
   localparam int ID_W    = 16;
   localparam int BATT_W  = 16;
   localparam int LEVEL_W = 10;
   localparam int TIME_W  = 32;
   localparam int SLOT_W  = 2;
   localparam int BICON_W = 2;
   localparam int WICON_W = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int NUM_LEVELS = 4;

   localparam logic [CSR_IDX_W-1:0] REG_BATT_HIGH = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BATT_MID  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BATT_LOW  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_WATER_T1  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_WATER_T2  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_WATER_T3  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_WATER_T4  = 3'd6;

   localparam logic [BATT_W-1:0]  RST_BATT_HIGH = 16'd3700;
   localparam logic [BATT_W-1:0]  RST_BATT_MID  = 16'd3600;
   localparam logic [BATT_W-1:0]  RST_BATT_LOW  = 16'd3400;
   localparam logic [LEVEL_W-1:0] RST_WATER_T1  = 10'd1000;
   localparam logic [LEVEL_W-1:0] RST_WATER_T2  = 10'd800;
   localparam logic [LEVEL_W-1:0] RST_WATER_T3  = 10'd500;
   localparam logic [LEVEL_W-1:0] RST_WATER_T4  = 10'd300;
   localparam logic [LEVEL_W-1:0] ABSENT_LEVEL  = 10'd1023;

   typedef struct packed {
      logic [MAC_W-1:0]  mac;
      logic [ID_W-1:0]   msg_id;
      logic [TIME_W-1:0] last_seen;
   } entry_type;

   typedef struct packed {
      logic start;
      logic scan;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic scan_last;
   } sts_type;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_LAST  = 4'b0100,
      ST_WRITE = 4'b1000
   } state_type;

   function automatic logic [BICON_W-1:0] batt_icon(
      input logic [BATT_W-1:0] v,
      input logic [BATT_W-1:0] high,
      input logic [BATT_W-1:0] mid,
      input logic [BATT_W-1:0] low
   );
      logic [BICON_W-1:0] icon;
      if (v > high) begin
         icon = 2'd3;
      end else if (v > mid) begin
         icon = 2'd2;
      end else if (v > low) begin
         icon = 2'd1;
      end else begin
         icon = 2'd0;
      end
      return icon;
   endfunction

   function automatic logic [WICON_W-1:0] water_icon(
      input logic [LEVEL_W-1:0] v,
      input logic [LEVEL_W-1:0] t1,
      input logic [LEVEL_W-1:0] t2,
      input logic [LEVEL_W-1:0] t3,
      input logic [LEVEL_W-1:0] t4
   );
      logic [WICON_W-1:0] icon;
      if (v == ABSENT_LEVEL) begin
         icon = 3'd0;
      end else if (v > t1) begin
         icon = 3'd1;
      end else if (v > t2) begin
         icon = 3'd2;
      end else if (v > t3) begin
         icon = 3'd3;
      end else if (v > t4) begin
         icon = 3'd4;
      end else begin
         icon = 3'd5;
      end
      return icon;
   endfunction

endpackage

@@ rtl/sstc_ctrl.sv @@
// ---------------------------------------------------------------------------
// Sensor slot table classifier controller
// Sequences accept, table scan, final evaluation and write-back, and owns
// the result valid flag.
// ---------------------------------------------------------------------------
module sstc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  sstc_pkg::sts_type sts,
   output sstc_pkg::cmd_type cmd
);

   sstc_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         sstc_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = sstc_pkg::ST_SCAN;
            end
         end
         sstc_pkg::ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_last) begin
               state_in = sstc_pkg::ST_LAST;
            end
         end
         sstc_pkg::ST_LAST: begin
            state_in = sstc_pkg::ST_WRITE;
         end
         sstc_pkg::ST_WRITE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.commit = 1'b1;
               state_in   = sstc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sstc_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sstc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != sstc_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

@@ rtl/sstc_dpath.sv @@
// ---------------------------------------------------------------------------
// Sensor slot table classifier datapath
// Holds the thresholds, the input word, the slot table memory with its
// valid bits, the scan counter, the candidate slots and the result word.
// ---------------------------------------------------------------------------
module sstc_dpath #(
   parameter int SLOTS = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  sstc_pkg::cmd_type                   cmd,
   output sstc_pkg::sts_type                   sts,
   input  logic                                csr_we,
   input  logic [sstc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sstc_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic [sstc_pkg::MAC_W-1:0]          req_sensor_mac,
   input  logic [sstc_pkg::ID_W-1:0]           req_msg_id,
   input  logic [sstc_pkg::BATT_W-1:0]         req_battery_mv,
   input  logic [sstc_pkg::LEVEL_W-1:0]        req_level_1,
   input  logic [sstc_pkg::LEVEL_W-1:0]        req_level_2,
   input  logic [sstc_pkg::LEVEL_W-1:0]        req_level_3,
   input  logic [sstc_pkg::LEVEL_W-1:0]        req_level_4,
   input  logic [sstc_pkg::TIME_W-1:0]         req_now_ms,
   output logic [sstc_pkg::SLOT_W-1:0]         rsp_slot,
   output logic                                rsp_table_full,
   output logic [sstc_pkg::BICON_W-1:0]        rsp_battery_icon,
   output logic [sstc_pkg::WICON_W-1:0]        rsp_water_icon_1,
   output logic [sstc_pkg::WICON_W-1:0]        rsp_water_icon_2,
   output logic [sstc_pkg::WICON_W-1:0]        rsp_water_icon_3,
   output logic [sstc_pkg::WICON_W-1:0]        rsp_water_icon_4,
   output logic [sstc_pkg::ID_W-1:0]           rsp_prev_msg_id,
   output logic [sstc_pkg::TIME_W-1:0]         rsp_last_seen_ms
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   // Threshold registers.
   logic [sstc_pkg::BATT_W-1:0]  batt_high_ff, batt_mid_ff, batt_low_ff;
   logic [sstc_pkg::LEVEL_W-1:0] water_t1_ff, water_t2_ff, water_t3_ff, water_t4_ff;

   // Captured input word.
   logic [sstc_pkg::MAC_W-1:0]   mac_ff;
   logic [sstc_pkg::ID_W-1:0]    id_ff;
   logic [sstc_pkg::BATT_W-1:0]  batt_ff;
   logic [sstc_pkg::LEVEL_W-1:0] level_ff [sstc_pkg::NUM_LEVELS];
   logic [sstc_pkg::TIME_W-1:0]  now_ff;

   // Slot table.
   sstc_pkg::entry_type table_mem [SLOTS];
   logic [SLOTS-1:0]    valid_ff;
   sstc_pkg::entry_type rd_data_ff;
   logic                rd_vld_ff;
   logic [IDX_W-1:0]    rd_idx_ff;
   logic                rd_pend_ff;
   logic [IDX_W-1:0]    scan_cnt_ff;
   sstc_pkg::entry_type ent;
   logic                hit_now, free_now;

   // Candidates gathered during the scan.
   logic                        hit_ff, free_ff;
   logic [IDX_W-1:0]            hit_idx_ff, free_idx_ff;
   logic [sstc_pkg::ID_W-1:0]   hit_msg_ff, free_msg_ff, zero_msg_ff;
   logic [sstc_pkg::TIME_W-1:0] hit_seen_ff, free_seen_ff, zero_seen_ff;

   // Write-back selection.
   logic [IDX_W-1:0]            sel_idx;
   logic [IDX_W+1:0]            sel_idx_ext;
   logic                        sel_full;
   logic [sstc_pkg::ID_W-1:0]   sel_prev;
   logic [sstc_pkg::TIME_W-1:0] sel_seen, new_seen;

   always_ff @(posedge clock) begin
      if (reset) begin
         batt_high_ff <= sstc_pkg::RST_BATT_HIGH;
         batt_mid_ff  <= sstc_pkg::RST_BATT_MID;
         batt_low_ff  <= sstc_pkg::RST_BATT_LOW;
         water_t1_ff  <= sstc_pkg::RST_WATER_T1;
         water_t2_ff  <= sstc_pkg::RST_WATER_T2;
         water_t3_ff  <= sstc_pkg::RST_WATER_T3;
         water_t4_ff  <= sstc_pkg::RST_WATER_T4;
      end else if (csr_we) begin
         unique case (csr_index)
            sstc_pkg::REG_BATT_HIGH: batt_high_ff <= csr_wdata;
            sstc_pkg::REG_BATT_MID:  batt_mid_ff  <= csr_wdata;
            sstc_pkg::REG_BATT_LOW:  batt_low_ff  <= csr_wdata;
            sstc_pkg::REG_WATER_T1:  water_t1_ff  <= csr_wdata[sstc_pkg::LEVEL_W-1:0];
            sstc_pkg::REG_WATER_T2:  water_t2_ff  <= csr_wdata[sstc_pkg::LEVEL_W-1:0];
            sstc_pkg::REG_WATER_T3:  water_t3_ff  <= csr_wdata[sstc_pkg::LEVEL_W-1:0];
            sstc_pkg::REG_WATER_T4:  water_t4_ff  <= csr_wdata[sstc_pkg::LEVEL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         mac_ff      <= req_sensor_mac;
         id_ff       <= req_msg_id;
         batt_ff     <= req_battery_mv;
         level_ff[0] <= req_level_1;
         level_ff[1] <= req_level_2;
         level_ff[2] <= req_level_3;
         level_ff[3] <= req_level_4;
         now_ff      <= req_now_ms;
      end
   end

   // Scan counter and read pipeline control.
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_cnt_ff <= '0;
         rd_pend_ff  <= 1'b0;
      end else begin
         rd_pend_ff <= cmd.scan;
         if (cmd.start) begin
            scan_cnt_ff <= '0;
         end else if (cmd.scan && (scan_cnt_ff != LAST_IDX)) begin
            scan_cnt_ff <= scan_cnt_ff + 1'b1;
         end
      end
   end

   assign sts.scan_last = (scan_cnt_ff == LAST_IDX);

   // Table memory: one read port for the scan, one write port for write-back.
   always_ff @(posedge clock) begin
      if (cmd.scan) begin
         rd_data_ff <= table_mem[scan_cnt_ff];
         rd_vld_ff  <= valid_ff[scan_cnt_ff];
         rd_idx_ff  <= scan_cnt_ff;
      end
      if (cmd.commit) begin
         table_mem[sel_idx] <= '{mac: mac_ff, msg_id: id_ff, last_seen: new_seen};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.commit) begin
         valid_ff[sel_idx] <= 1'b1;
      end
   end

   // An entry never written reads as the cleared value.
   always_comb begin
      ent      = rd_vld_ff ? rd_data_ff : '0;
      hit_now  = (ent.mac == mac_ff);
      free_now = (ent.mac[sstc_pkg::MAC_W-1 -: 8] == 8'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff  <= 1'b0;
         free_ff <= 1'b0;
      end else if (cmd.start) begin
         hit_ff  <= 1'b0;
         free_ff <= 1'b0;
      end else if (rd_pend_ff) begin
         if (!hit_ff && hit_now) begin
            hit_ff <= 1'b1;
         end
         if (!free_ff && free_now) begin
            free_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_pend_ff) begin
         if (!hit_ff && hit_now) begin
            hit_idx_ff  <= rd_idx_ff;
            hit_msg_ff  <= ent.msg_id;
            hit_seen_ff <= ent.last_seen;
         end
         if (!free_ff && free_now) begin
            free_idx_ff  <= rd_idx_ff;
            free_msg_ff  <= ent.msg_id;
            free_seen_ff <= ent.last_seen;
         end
         if (rd_idx_ff == '0) begin
            zero_msg_ff  <= ent.msg_id;
            zero_seen_ff <= ent.last_seen;
         end
      end
   end

   always_comb begin
      if (hit_ff) begin
         sel_idx  = hit_idx_ff;
         sel_prev = hit_msg_ff;
         sel_seen = hit_seen_ff;
         sel_full = 1'b0;
      end else if (free_ff) begin
         sel_idx  = free_idx_ff;
         sel_prev = free_msg_ff;
         sel_seen = free_seen_ff;
         sel_full = 1'b0;
      end else begin
         sel_idx  = '0;
         sel_prev = zero_msg_ff;
         sel_seen = zero_seen_ff;
         sel_full = 1'b1;
      end
      new_seen    = (id_ff != sel_prev) ? now_ff : sel_seen;
      sel_idx_ext = {2'b00, sel_idx};
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_slot         <= sel_idx_ext[sstc_pkg::SLOT_W-1:0];
         rsp_table_full   <= sel_full;
         rsp_battery_icon <= sstc_pkg::batt_icon(batt_ff, batt_high_ff, batt_mid_ff,
                                                 batt_low_ff);
         rsp_water_icon_1 <= sstc_pkg::water_icon(level_ff[0], water_t1_ff, water_t2_ff,
                                                  water_t3_ff, water_t4_ff);
         rsp_water_icon_2 <= sstc_pkg::water_icon(level_ff[1], water_t1_ff, water_t2_ff,
                                                  water_t3_ff, water_t4_ff);
         rsp_water_icon_3 <= sstc_pkg::water_icon(level_ff[2], water_t1_ff, water_t2_ff,
                                                  water_t3_ff, water_t4_ff);
         rsp_water_icon_4 <= sstc_pkg::water_icon(level_ff[3], water_t1_ff, water_t2_ff,
                                                  water_t3_ff, water_t4_ff);
         rsp_prev_msg_id  <= sel_prev;
         rsp_last_seen_ms <= new_seen;
      end
   end

endmodule

@@ rtl/sensor_slot_table_classifier.sv @@
// ---------------------------------------------------------------------------
// Sensor slot table classifier
// Each request word is one sensor report. Its MAC is looked up in a table
// of SLOTS entries; the matching entry, else the first free entry, else
// slot 0 takes the report. The response word gives the slot, battery and
// water-level icons, the previous message id and the entry's time stamp.
//
// Both channels use valid and stall; a word moves when valid is high and
// stall is low. Thresholds are written through the csr_ port while idle.
// The table is scanned one entry per cycle through its single read port;
// the result is then evaluated, written back and registered into the
// response word. A new request is taken only once the controller is idle
// again. A finished response waits in an output register while the
// receiver stalls; the write-back of the next report waits until that
// register is free. Reset clears the table valid bits and the response
// valid flag and loads the default thresholds; no clearing pass is run.
// ---------------------------------------------------------------------------
module sensor_slot_table_classifier #(
   parameter int SLOTS = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [sstc_pkg::MAC_W-1:0]      req_sensor_mac,
   input  logic [sstc_pkg::ID_W-1:0]       req_msg_id,
   input  logic [sstc_pkg::BATT_W-1:0]     req_battery_mv,
   input  logic [sstc_pkg::LEVEL_W-1:0]    req_level_1,
   input  logic [sstc_pkg::LEVEL_W-1:0]    req_level_2,
   input  logic [sstc_pkg::LEVEL_W-1:0]    req_level_3,
   input  logic [sstc_pkg::LEVEL_W-1:0]    req_level_4,
   input  logic [sstc_pkg::TIME_W-1:0]     req_now_ms,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [sstc_pkg::SLOT_W-1:0]     rsp_slot,
   output logic                            rsp_table_full,
   output logic [sstc_pkg::BICON_W-1:0]    rsp_battery_icon,
   output logic [sstc_pkg::WICON_W-1:0]    rsp_water_icon_1,
   output logic [sstc_pkg::WICON_W-1:0]    rsp_water_icon_2,
   output logic [sstc_pkg::WICON_W-1:0]    rsp_water_icon_3,
   output logic [sstc_pkg::WICON_W-1:0]    rsp_water_icon_4,
   output logic [sstc_pkg::ID_W-1:0]       rsp_prev_msg_id,
   output logic [sstc_pkg::TIME_W-1:0]     rsp_last_seen_ms,
   input  logic                            csr_we,
   input  logic [sstc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sstc_pkg::CSR_DATA_W-1:0] csr_wdata
);

   sstc_pkg::cmd_type cmd;
   sstc_pkg::sts_type sts;

   sstc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   sstc_dpath #(
      .SLOTS (SLOTS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_sensor_mac   (req_sensor_mac),
      .req_msg_id       (req_msg_id),
      .req_battery_mv   (req_battery_mv),
      .req_level_1      (req_level_1),
      .req_level_2      (req_level_2),
      .req_level_3      (req_level_3),
      .req_level_4      (req_level_4),
      .req_now_ms       (req_now_ms),
      .rsp_slot         (rsp_slot),
      .rsp_table_full   (rsp_table_full),
      .rsp_battery_icon (rsp_battery_icon),
      .rsp_water_icon_1 (rsp_water_icon_1),
      .rsp_water_icon_2 (rsp_water_icon_2),
      .rsp_water_icon_3 (rsp_water_icon_3),
      .rsp_water_icon_4 (rsp_water_icon_4),
      .rsp_prev_msg_id  (rsp_prev_msg_id),
      .rsp_last_seen_ms (rsp_last_seen_ms)
   );

   // Once a word is taken the block stays busy while it scans the table.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken but block not busy in the next cycle");

   // A full table always reuses slot 0.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_table_full) |-> (rsp_slot == '0))
      else $error("table full reported for a slot other than 0");

   // A response only appears as the block finishes a word it was working on.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response raised while the block was idle");

endmodule

@@ sim/testbench.sv @@
// ---------------------------------------------------------------------------
// Sensor slot table classifier testbench
// Sends sensor report words through the request channel with random gaps
// and takes response words with random stalls. Every accepted report is run
// through a predictor of the slot table and the icon thresholds, and each
// response word is checked field by field against the oldest prediction.
// The thresholds are reprogrammed between phases once the block is idle.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

typedef struct packed {
   logic [sstc_pkg::MAC_W-1:0]                              sensor_mac;
   logic [sstc_pkg::ID_W-1:0]                               msg_id;
   logic [sstc_pkg::BATT_W-1:0]                             battery_mv;
   logic [sstc_pkg::NUM_LEVELS-1:0][sstc_pkg::LEVEL_W-1:0]  level;
   logic [sstc_pkg::TIME_W-1:0]                             now_ms;
} sensor_report_type;

typedef struct packed {
   logic [sstc_pkg::SLOT_W-1:0]                             slot;
   logic                                                    table_full;
   logic [sstc_pkg::BICON_W-1:0]                            battery_icon;
   logic [sstc_pkg::NUM_LEVELS-1:0][sstc_pkg::WICON_W-1:0]  water_icon;
   logic [sstc_pkg::ID_W-1:0]                               prev_msg_id;
   logic [sstc_pkg::TIME_W-1:0]                             last_seen_ms;
} status_word_type;

class slot_table_board;
   localparam int ENTRIES = 4;

   logic [sstc_pkg::BATT_W-1:0]  batt_thr [3];
   logic [sstc_pkg::LEVEL_W-1:0] water_thr [4];
   logic [sstc_pkg::MAC_W-1:0]   mac_tab [ENTRIES];
   logic [sstc_pkg::ID_W-1:0]    id_tab [ENTRIES];
   logic [sstc_pkg::TIME_W-1:0]  seen_tab [ENTRIES];
   status_word_type              pending [$];
   int                           errors;

   function new();
      batt_thr[0] = sstc_pkg::RST_BATT_HIGH;
      batt_thr[1] = sstc_pkg::RST_BATT_MID;
      batt_thr[2] = sstc_pkg::RST_BATT_LOW;
      water_thr[0] = sstc_pkg::RST_WATER_T1;
      water_thr[1] = sstc_pkg::RST_WATER_T2;
      water_thr[2] = sstc_pkg::RST_WATER_T3;
      water_thr[3] = sstc_pkg::RST_WATER_T4;
      for (int i = 0; i < ENTRIES; i++) begin
         mac_tab[i] = '0;
         id_tab[i] = '0;
         seen_tab[i] = '0;
      end
      errors = 0;
   endfunction

   function void set_register(logic [sstc_pkg::CSR_IDX_W-1:0] idx,
                              logic [sstc_pkg::CSR_DATA_W-1:0] data);
      case (idx)
         sstc_pkg::REG_BATT_HIGH: batt_thr[0] = data;
         sstc_pkg::REG_BATT_MID:  batt_thr[1] = data;
         sstc_pkg::REG_BATT_LOW:  batt_thr[2] = data;
         sstc_pkg::REG_WATER_T1:  water_thr[0] = data[sstc_pkg::LEVEL_W-1:0];
         sstc_pkg::REG_WATER_T2:  water_thr[1] = data[sstc_pkg::LEVEL_W-1:0];
         sstc_pkg::REG_WATER_T3:  water_thr[2] = data[sstc_pkg::LEVEL_W-1:0];
         sstc_pkg::REG_WATER_T4:  water_thr[3] = data[sstc_pkg::LEVEL_W-1:0];
         default: ;
      endcase
   endfunction

   function logic [sstc_pkg::BICON_W-1:0] battery_bars(logic [sstc_pkg::BATT_W-1:0] mv);
      for (int k = 0; k < 3; k++) begin
         if (mv > batt_thr[k]) return sstc_pkg::BICON_W'(3 - k);
      end
      return '0;
   endfunction

   function logic [sstc_pkg::WICON_W-1:0] level_mark(logic [sstc_pkg::LEVEL_W-1:0] reading);
      if (reading == '1) return '0;
      for (int k = 0; k < 4; k++) begin
         if (reading > water_thr[k]) return sstc_pkg::WICON_W'(k + 1);
      end
      return sstc_pkg::WICON_W'(5);
   endfunction

   function void note_report(sensor_report_type r);
      status_word_type e;
      int hit;
      hit = -1;
      for (int i = 0; i < ENTRIES; i++) begin
         if (hit < 0 && mac_tab[i] == r.sensor_mac) hit = i;
      end
      for (int i = 0; i < ENTRIES; i++) begin
         if (hit < 0 && mac_tab[i][sstc_pkg::MAC_W-1:sstc_pkg::MAC_W-8] == 8'h00) hit = i;
      end
      e.table_full = 1'b0;
      if (hit < 0) begin
         hit = 0;
         e.table_full = 1'b1;
      end
      e.prev_msg_id = id_tab[hit];
      mac_tab[hit] = r.sensor_mac;
      id_tab[hit] = r.msg_id;
      if (r.msg_id != e.prev_msg_id) seen_tab[hit] = r.now_ms;
      e.slot = sstc_pkg::SLOT_W'(hit);
      e.battery_icon = battery_bars(r.battery_mv);
      for (int k = 0; k < sstc_pkg::NUM_LEVELS; k++) begin
         e.water_icon[k] = level_mark(r.level[k]);
      end
      e.last_seen_ms = seen_tab[hit];
      pending.push_back(e);
   endfunction

   function void match_field(string field, logic [sstc_pkg::MAC_W-1:0] want,
                             logic [sstc_pkg::MAC_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         errors++;
      end
   endfunction

   function void check_reply(status_word_type got);
      status_word_type want;
      if (pending.size() == 0) begin
         $error("response word arrived with no report outstanding");
         errors++;
         return;
      end
      want = pending.pop_front();
      match_field("slot", want.slot, got.slot);
      match_field("table_full", want.table_full, got.table_full);
      match_field("battery_icon", want.battery_icon, got.battery_icon);
      for (int k = 0; k < sstc_pkg::NUM_LEVELS; k++) begin
         match_field($sformatf("water_icon_%0d", k + 1), want.water_icon[k],
                     got.water_icon[k]);
      end
      match_field("prev_msg_id", want.prev_msg_id, got.prev_msg_id);
      match_field("last_seen_ms", want.last_seen_ms, got.last_seen_ms);
   endfunction
endclass

module testbench;

   localparam int SLOT_COUNT   = 4;
   localparam int SETTLE       = 16;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int PHASE_ITEMS  = 110;
   localparam logic [sstc_pkg::CSR_IDX_W-1:0] REG_SPARE = 3'd7;

   typedef enum int {SET_ZERO, SET_MAX, SET_REVERSED, SET_RANDOM, SET_DEFAULT} setting_kind_type;

   logic clock = 1'b0;
   logic reset;
   logic req_valid, req_stall;
   logic [sstc_pkg::MAC_W-1:0]   req_sensor_mac;
   logic [sstc_pkg::ID_W-1:0]    req_msg_id;
   logic [sstc_pkg::BATT_W-1:0]  req_battery_mv;
   logic [sstc_pkg::LEVEL_W-1:0] req_level_1, req_level_2, req_level_3, req_level_4;
   logic [sstc_pkg::TIME_W-1:0]  req_now_ms;
   logic rsp_valid, rsp_stall;
   logic [sstc_pkg::SLOT_W-1:0]  rsp_slot;
   logic                         rsp_table_full;
   logic [sstc_pkg::BICON_W-1:0] rsp_battery_icon;
   logic [sstc_pkg::WICON_W-1:0] rsp_water_icon_1, rsp_water_icon_2;
   logic [sstc_pkg::WICON_W-1:0] rsp_water_icon_3, rsp_water_icon_4;
   logic [sstc_pkg::ID_W-1:0]    rsp_prev_msg_id;
   logic [sstc_pkg::TIME_W-1:0]  rsp_last_seen_ms;
   logic                            csr_we;
   logic [sstc_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [sstc_pkg::CSR_DATA_W-1:0] csr_wdata;

   slot_table_board board = new();
   int cycle_count = 0;
   int max_idle = 6;
   int pool_span = 7;
   logic [sstc_pkg::CSR_DATA_W-1:0] cur_set [7];
   logic [sstc_pkg::MAC_W-1:0] mac_pool [8];
   logic [sstc_pkg::ID_W-1:0]  last_id [8];

   sensor_slot_table_classifier #(.SLOTS(SLOT_COUNT)) dut (.*);

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic sensor_report_type make_report(
      logic [sstc_pkg::MAC_W-1:0] mac, logic [sstc_pkg::ID_W-1:0] id,
      logic [sstc_pkg::BATT_W-1:0] mv,
      logic [sstc_pkg::LEVEL_W-1:0] l1, logic [sstc_pkg::LEVEL_W-1:0] l2,
      logic [sstc_pkg::LEVEL_W-1:0] l3, logic [sstc_pkg::LEVEL_W-1:0] l4,
      logic [sstc_pkg::TIME_W-1:0] now
   );
      sensor_report_type r;
      r.sensor_mac = mac;
      r.msg_id = id;
      r.battery_mv = mv;
      r.level[0] = l1;
      r.level[1] = l2;
      r.level[2] = l3;
      r.level[3] = l4;
      r.now_ms = now;
      return r;
   endfunction

   // Mostly nodes from a small pool, so that entries are matched, freed and
   // overwritten often; message ids tend to repeat or step by one.
   function automatic sensor_report_type random_report();
      sensor_report_type r;
      int pick;
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 85) begin
         pick = $urandom_range(0, pool_span);
         r.sensor_mac = mac_pool[pick];
      end else begin
         pick = -1;
         r.sensor_mac = sstc_pkg::MAC_W'({$urandom(), $urandom()});
         if ($urandom_range(0, 3) == 0) begin
            r.sensor_mac[sstc_pkg::MAC_W-1:sstc_pkg::MAC_W-8] = 8'h00;
         end
      end
      roll = $urandom_range(0, 9);
      if (pick >= 0 && roll < 4) begin
         r.msg_id = last_id[pick];
      end else if (pick >= 0 && roll < 7) begin
         r.msg_id = last_id[pick] + 1'b1;
      end else begin
         r.msg_id = sstc_pkg::ID_W'($urandom());
      end
      if (pick >= 0) last_id[pick] = r.msg_id;
      if ($urandom_range(0, 1) == 0) begin
         r.battery_mv = sstc_pkg::BATT_W'($urandom());
      end else begin
         r.battery_mv = sstc_pkg::BATT_W'(cur_set[$urandom_range(0, 2)]
                                          + $urandom_range(0, 2) - 1);
      end
      for (int k = 0; k < sstc_pkg::NUM_LEVELS; k++) begin
         roll = $urandom_range(0, 9);
         if (roll < 2) begin
            r.level[k] = sstc_pkg::ABSENT_LEVEL;
         end else if (roll < 6) begin
            r.level[k] = sstc_pkg::LEVEL_W'($urandom());
         end else begin
            r.level[k] = sstc_pkg::LEVEL_W'(cur_set[3 + $urandom_range(0, 3)]
                                            + $urandom_range(0, 2) - 1);
         end
      end
      r.now_ms = sstc_pkg::TIME_W'($urandom());
      return r;
   endfunction

   task automatic send_report(input sensor_report_type r);
      int gap;
      gap = $urandom_range(0, max_idle);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sensor_mac <= r.sensor_mac;
      req_msg_id <= r.msg_id;
      req_battery_mv <= r.battery_mv;
      req_level_1 <= r.level[0];
      req_level_2 <= r.level[1];
      req_level_3 <= r.level[2];
      req_level_4 <= r.level[3];
      req_now_ms <= r.now_ms;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_report(r);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Upper bits of the level thresholds are filled with noise, since only
   // their low ten bits are kept.
   task automatic program_setting(input setting_kind_type kind);
      logic [sstc_pkg::CSR_DATA_W-1:0] data;
      for (int i = 0; i < 7; i++) begin
         case (kind)
            SET_ZERO:     cur_set[i] = '0;
            SET_MAX:      cur_set[i] = (i < 3) ? 16'hFFFF : 16'h03FF;
            SET_REVERSED: cur_set[i] = (i < 3) ? 16'(1000 + 1500 * i)
                                               : 16'(100 + 250 * (i - 3));
            SET_RANDOM:   cur_set[i] = (i < 3) ? 16'($urandom())
                                               : 16'($urandom_range(0, 1023));
            default: begin
               cur_set[0] = sstc_pkg::RST_BATT_HIGH;
               cur_set[1] = sstc_pkg::RST_BATT_MID;
               cur_set[2] = sstc_pkg::RST_BATT_LOW;
               cur_set[3] = 16'(sstc_pkg::RST_WATER_T1);
               cur_set[4] = 16'(sstc_pkg::RST_WATER_T2);
               cur_set[5] = 16'(sstc_pkg::RST_WATER_T3);
               cur_set[6] = 16'(sstc_pkg::RST_WATER_T4);
            end
         endcase
      end
      for (int i = sstc_pkg::REG_BATT_HIGH; i <= REG_SPARE; i++) begin
         if (i == REG_SPARE) begin
            data = sstc_pkg::CSR_DATA_W'($urandom());
         end else if (i >= sstc_pkg::REG_WATER_T1) begin
            data = {6'($urandom()), cur_set[i][sstc_pkg::LEVEL_W-1:0]};
         end else begin
            data = cur_set[i];
         end
         csr_we <= 1'b1;
         csr_index <= sstc_pkg::CSR_IDX_W'(i);
         csr_wdata <= data;
         @(posedge clock);
         board.set_register(sstc_pkg::CSR_IDX_W'(i), data);
      end
      csr_we <= 1'b0;
   endtask

   initial begin
      status_word_type got;
      int wait_n;
      rsp_stall <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         wait_n = $urandom_range(0, max_idle);
         if (wait_n > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         got.slot = rsp_slot;
         got.table_full = rsp_table_full;
         got.battery_icon = rsp_battery_icon;
         got.water_icon[0] = rsp_water_icon_1;
         got.water_icon[1] = rsp_water_icon_2;
         got.water_icon[2] = rsp_water_icon_3;
         got.water_icon[3] = rsp_water_icon_4;
         got.prev_msg_id = rsp_prev_msg_id;
         got.last_seen_ms = rsp_last_seen_ms;
         board.check_reply(got);
      end
   end

   initial begin
      setting_kind_type plan [10];
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_sensor_mac <= '0;
      req_msg_id <= '0;
      req_battery_mv <= '0;
      req_level_1 <= '0;
      req_level_2 <= '0;
      req_level_3 <= '0;
      req_level_4 <= '0;
      req_now_ms <= '0;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      cur_set[0] = sstc_pkg::RST_BATT_HIGH;
      cur_set[1] = sstc_pkg::RST_BATT_MID;
      cur_set[2] = sstc_pkg::RST_BATT_LOW;
      cur_set[3] = 16'(sstc_pkg::RST_WATER_T1);
      cur_set[4] = 16'(sstc_pkg::RST_WATER_T2);
      cur_set[5] = 16'(sstc_pkg::RST_WATER_T3);
      cur_set[6] = 16'(sstc_pkg::RST_WATER_T4);
      for (int i = 0; i < 8; i++) begin
         mac_pool[i] = sstc_pkg::MAC_W'({$urandom(), $urandom()});
         if (mac_pool[i][sstc_pkg::MAC_W-1:sstc_pkg::MAC_W-8] == 8'h00) begin
            mac_pool[i][sstc_pkg::MAC_W-1] = 1'b1;
         end
         last_id[i] = sstc_pkg::ID_W'($urandom());
      end
      mac_pool[2][sstc_pkg::MAC_W-1:sstc_pkg::MAC_W-8] = 8'h00;
      mac_pool[5][sstc_pkg::MAC_W-1:sstc_pkg::MAC_W-8] = 8'h00;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed words at the reset thresholds: first entry, repeated and
      // changed message ids, the free-entry rule for a zero top byte, a full
      // table, and readings on and just above each threshold.
      send_report(make_report(48'h0A00_0000_0001, 16'd5, 16'd0, 10'd0, 10'd1023, 10'd1000,
                              10'd1001, 32'd1));
      send_report(make_report(48'h0A00_0000_0001, 16'd5, 16'd3400, 10'd300, 10'd301,
                              10'd500, 10'd501, 32'd2));
      send_report(make_report(48'h0A00_0000_0001, 16'd6, 16'd3401, 10'd800, 10'd801,
                              10'd1022, 10'd1023, 32'd3));
      send_report(make_report(48'h0012_3456_7890, 16'd0, 16'd3600, 10'd299, 10'd0, 10'd1,
                              10'd999, 32'd4));
      send_report(make_report(48'h00AB_CDEF_0123, 16'd7, 16'd3601, 10'd499, 10'd799,
                              10'd1000, 10'd1023, 32'd5));
      send_report(make_report(48'hFFFF_FFFF_FFFF, 16'hFFFF, 16'hFFFF, 10'd1023, 10'd1023,
                              10'd1023, 10'd1023, 32'hFFFF_FFFF));
      send_report(make_report(48'h8000_0000_0000, 16'd1, 16'd3700, 10'd1022, 10'd0,
                              10'd300, 10'd301, 32'd7));
      send_report(make_report(48'h7F00_0000_0000, 16'd3, 16'd3701, 10'd500, 10'd501,
                              10'd800, 10'd801, 32'd8));
      send_report(make_report(48'h1122_3344_5566, 16'd2, 16'd3599, 10'd1, 10'd2, 10'd3,
                              10'd4, 32'd9));
      send_report(make_report(48'h0000_0000_0000, 16'd0, 16'd3399, 10'd1023, 10'd1000,
                              10'd999, 10'd0, 32'd10));
      send_report(make_report(48'h0A00_0000_0001, 16'd9, 16'd1, 10'd300, 10'd500, 10'd800,
                              10'd1000, 32'd11));
      send_report(make_report(48'hFFFF_FFFF_FFFF, 16'hFFFF, 16'd3699, 10'd1022, 10'd1021,
                              10'd2, 10'd1, 32'd12));
      send_report(make_report(48'h8000_0000_0000, 16'd2, 16'hFFFE, 10'd0, 10'd1023,
                              10'd1023, 10'd0, 32'd13));
      send_report(make_report(48'h1122_3344_5566, 16'h0000, 16'd0, 10'd1023, 10'd0, 10'd1022,
                              10'd300, 32'hFFFF_FFFE));
      wait_drained();

      plan = '{SET_ZERO, SET_MAX, SET_REVERSED, SET_RANDOM, SET_RANDOM,
               SET_RANDOM, SET_RANDOM, SET_RANDOM, SET_RANDOM, SET_DEFAULT};
      for (int p = 0; p < 10; p++) begin
         program_setting(plan[p]);
         max_idle = (p % 3 == 1) ? 0 : 6;
         pool_span = $urandom_range(3, 7);
         for (int n = 0; n < PHASE_ITEMS; n++) send_report(random_report());
         wait_drained();
      end

      if (board.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
